### rtl/smx_pkg.sv
`default_nettype none
package smx_pkg;

  localparam int SEGMENT_WORDS = 1024;
  localparam int SEGMENTS      = 4;
  localparam int WORD_BYTES    = 4;
  localparam int MEM_DEPTH     = SEGMENTS * SEGMENT_WORDS;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int SEG_AW        = $clog2(SEGMENT_WORDS);
  localparam int OFF_W         = SEG_AW + 2;
  localparam logic [31:0] WIN_BYTES = 32'(SEGMENT_WORDS * WORD_BYTES);

  localparam logic [1:0] OPN_WRITE = 2'd0;
  localparam logic [1:0] OPN_START = 2'd1;
  localparam logic [1:0] OPN_STEP  = 2'd2;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EXIT    = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN = 3'd2;
  localparam logic [2:0] STAT_FAULT   = 3'd3;
  localparam logic [2:0] STAT_DIV0    = 3'd4;

  localparam logic [2:0] CFG_TEXT  = 3'd0;
  localparam logic [2:0] CFG_DATA  = 3'd1;
  localparam logic [2:0] CFG_STACK = 3'd2;
  localparam logic [2:0] CFG_HEAP  = 3'd3;
  localparam logic [2:0] CFG_ENTRY = 3'd4;

  localparam logic [5:0] OP_LEA  = 6'd1;
  localparam logic [5:0] OP_IMM  = 6'd2;
  localparam logic [5:0] OP_JMP  = 6'd4;
  localparam logic [5:0] OP_CALL = 6'd5;
  localparam logic [5:0] OP_JZ   = 6'd6;
  localparam logic [5:0] OP_JNZ  = 6'd7;
  localparam logic [5:0] OP_ENT  = 6'd8;
  localparam logic [5:0] OP_ADJ  = 6'd9;
  localparam logic [5:0] OP_LEV  = 6'd10;
  localparam logic [5:0] OP_LI   = 6'd11;
  localparam logic [5:0] OP_SI   = 6'd12;
  localparam logic [5:0] OP_LC   = 6'd13;
  localparam logic [5:0] OP_SC   = 6'd14;
  localparam logic [5:0] OP_PUSH = 6'd15;
  localparam logic [5:0] OP_LOAD = 6'd16;
  localparam logic [5:0] OP_OR   = 6'd17;
  localparam logic [5:0] OP_XOR  = 6'd18;
  localparam logic [5:0] OP_AND  = 6'd19;
  localparam logic [5:0] OP_EQ   = 6'd20;
  localparam logic [5:0] OP_NE   = 6'd21;
  localparam logic [5:0] OP_LT   = 6'd22;
  localparam logic [5:0] OP_GT   = 6'd23;
  localparam logic [5:0] OP_LE   = 6'd24;
  localparam logic [5:0] OP_GE   = 6'd25;
  localparam logic [5:0] OP_SHL  = 6'd26;
  localparam logic [5:0] OP_SHR  = 6'd27;
  localparam logic [5:0] OP_ADD  = 6'd28;
  localparam logic [5:0] OP_SUB  = 6'd29;
  localparam logic [5:0] OP_MUL  = 6'd30;
  localparam logic [5:0] OP_DIV  = 6'd31;
  localparam logic [5:0] OP_MOD  = 6'd32;
  localparam logic [5:0] OP_EXIT = 6'd42;

  typedef struct packed {
    logic              hit;
    logic [MEM_AW-1:0] idx;
    logic [1:0]        lane;
  } loc_t;

  // first matching window wins: text, data, stack, heap
  function automatic loc_t locate(input logic [31:0] a, input logic [31:0] b0,
                                  input logic [31:0] b1, input logic [31:0] b2,
                                  input logic [31:0] b3);
    loc_t        r;
    logic [31:0] off;
    logic [31:0] bases [SEGMENTS];
    bases[0] = b0;
    bases[1] = b1;
    bases[2] = b2;
    bases[3] = b3;
    r = '0;
    for (int s = SEGMENTS - 1; s >= 0; s--) begin
      off = a - bases[s];
      if (off < WIN_BYTES) begin
        r.hit  = 1'b1;
        r.idx  = {2'(s), off[OFF_W-1:2]};
        r.lane = off[1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/smx_ram.sv
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/stack_machine_executor.sv
`default_nettype none
// Accumulator stack machine executing one request at a time.
// Request channel: in_operation, in_address, in_write_data are taken at a
// clock edge where start is high and busy is low. in_operation selects a
// memory word write, a program start at the entry point, or one instruction.
// Result channel: out_valid is high for exactly one cycle per request; the
// pc, ax, sp, bp and status ports are read in that cycle. The receiver cannot
// stall, so results are never held back.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the block is idle.
// Path from accepting edge to out_valid: a word write completes from idle; a
// start runs five window checks and five pushes through the single memory
// port (ST_CHK, ST_PUSH), ending early when a check faults; an instruction
// runs ST_DEC, then ST_RD1/ST_RD2 as its reads through the one registered
// memory read port need; DIV/MOD add ST_DIV, a one-bit-per-cycle divider.
// Requests do not overlap: busy drops in the result cycle, so the next
// request can be taken at the edge that takes the result.
// Reset: machine halted, ax and bp zero, sp at the top of the stack window,
// pc at the text base, window bases at their defaults. Memory is not cleared.
module stack_machine_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  output logic [31:0]      out_program_counter,
  output logic [31:0]      out_accumulator,
  output logic [31:0]      out_stack_pointer,
  output logic [31:0]      out_frame_pointer,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEC, ST_RD1, ST_RD2, ST_CHK, ST_PUSH, ST_DIV, ST_DFIN
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] pc_r, pc_nxt, ax_r, ax_nxt, sp_r, sp_nxt, bp_r, bp_nxt;
  logic        halted_r, halted_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  op_r, op_nxt;
  logic [31:0] t_r, t_nxt;
  logic [smx_pkg::MEM_AW-1:0] idx_r, idx_nxt;
  logic [1:0]  lane_r, lane_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic        nq_r, nq_nxt, nr_r, nr_nxt;
  logic [31:0] text_base_r, data_base_r, stack_base_r, heap_base_r;
  logic [15:0] entry_index_r;

  logic        mem_we;
  logic [smx_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata;
  logic [31:0] loc_addr;
  smx_pkg::loc_t loc;
  logic        loc_word;

  logic [31:0] top, rd, alu_w, rem_sh, div_w, merged;
  logic [32:0] diff;

  smx_ram #(.WIDTH(32), .DEPTH(smx_pkg::MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // the one address decoder shared by every access
  assign loc = smx_pkg::locate(loc_addr, text_base_r, data_base_r, stack_base_r,
                               heap_base_r);
  assign loc_word = loc.hit && (loc.lane == 2'd0);
  assign rd  = mem_rdata;
  assign top = stack_base_r + smx_pkg::WIN_BYTES;

  // shared ALU on the popped operand (rd) and ax
  always_comb begin
    unique case (op_r)
      smx_pkg::OP_OR:  alu_w = rd | ax_r;
      smx_pkg::OP_XOR: alu_w = rd ^ ax_r;
      smx_pkg::OP_AND: alu_w = rd & ax_r;
      smx_pkg::OP_EQ:  alu_w = {31'd0, rd == ax_r};
      smx_pkg::OP_NE:  alu_w = {31'd0, rd != ax_r};
      smx_pkg::OP_LT:  alu_w = {31'd0, $signed(rd) < $signed(ax_r)};
      smx_pkg::OP_GT:  alu_w = {31'd0, $signed(ax_r) < $signed(rd)};
      smx_pkg::OP_LE:  alu_w = {31'd0, !($signed(ax_r) < $signed(rd))};
      smx_pkg::OP_GE:  alu_w = {31'd0, !($signed(rd) < $signed(ax_r))};
      smx_pkg::OP_SHL: alu_w = rd << ax_r[4:0];
      smx_pkg::OP_SHR: alu_w = 32'($signed(rd) >>> ax_r[4:0]);
      smx_pkg::OP_ADD: alu_w = rd + ax_r;
      smx_pkg::OP_SUB: alu_w = rd - ax_r;
      smx_pkg::OP_MUL: alu_w = 32'(rd * ax_r);
      default:         alu_w = rd;
    endcase
  end

  // divider step: restoring, one quotient bit per cycle
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign div_w  = (op_r == smx_pkg::OP_DIV) ? (nq_r ? (32'd0 - quo_r) : quo_r)
                                             : (nr_r ? (32'd0 - rem_r) : rem_r);

  // byte merge for SC
  always_comb begin
    merged = rd;
    unique case (lane_r)
      2'd0: merged[7:0]   = ax_r[7:0];
      2'd1: merged[15:8]  = ax_r[7:0];
      2'd2: merged[23:16] = ax_r[7:0];
      2'd3: merged[31:24] = ax_r[7:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r; ax_nxt = ax_r; sp_nxt = sp_r; bp_nxt = bp_r;
    halted_nxt = halted_r; status_nxt = status_r; out_valid_nxt = 1'b0;
    op_nxt = op_r; t_nxt = t_r; idx_nxt = idx_r; lane_nxt = lane_r; cnt_nxt = cnt_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; nq_nxt = nq_r; nr_nxt = nr_r;
    loc_addr = pc_r;
    mem_we = 1'b0; mem_wdata = '0;
    mem_waddr = loc.idx; mem_raddr = loc.idx;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          status_nxt = smx_pkg::STAT_OK;
          unique case (in_operation)
            smx_pkg::OPN_WRITE: begin
              loc_addr = in_address;
              if (loc_word) begin
                mem_we = 1'b1;
                mem_wdata = in_write_data;
              end else begin
                status_nxt = smx_pkg::STAT_FAULT;
              end
            end
            smx_pkg::OPN_START: begin
              out_valid_nxt = 1'b0;
              cnt_nxt = '0;
              state_nxt = ST_CHK;
            end
            smx_pkg::OPN_STEP: begin
              if (halted_r) begin
                status_nxt = smx_pkg::STAT_EXIT;
              end else if (!loc_word) begin
                // opcode fetch faults: halt, registers hold
                status_nxt = smx_pkg::STAT_FAULT;
                halted_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt = ST_DEC;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CHK: begin
        loc_addr = top - {25'd0, cnt_r + 5'd1, 2'b00};
        if (!loc_word) begin
          status_nxt = smx_pkg::STAT_FAULT;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cnt_r == 5'd4) begin
          cnt_nxt = '0;
          state_nxt = ST_PUSH;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end

      ST_PUSH: begin
        loc_addr = top - {25'd0, cnt_r + 5'd1, 2'b00};
        mem_we = 1'b1;
        unique case (cnt_r)
          5'd0:    mem_wdata = {26'd0, smx_pkg::OP_EXIT};
          5'd1:    mem_wdata = {26'd0, smx_pkg::OP_PUSH};
          5'd4:    mem_wdata = top - 32'd8;
          default: mem_wdata = '0;
        endcase
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd4) begin
          sp_nxt = top - 32'd20;
          pc_nxt = text_base_r + {14'd0, entry_index_r, 2'b00};
          ax_nxt = '0;
          bp_nxt = '0;
          halted_nxt = 1'b0;
          status_nxt = smx_pkg::STAT_OK;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DEC: begin
        // opcode is on the read port; issue the next read where needed
        op_nxt = rd[5:0];
        loc_addr = pc_r + 32'd4;
        state_nxt = ST_RD1;
        if (rd[31:6] != 26'd0) begin
          op_nxt = '0;
          status_nxt = smx_pkg::STAT_UNKNOWN;
        end else begin
          unique case (rd[5:0])
            smx_pkg::OP_LEA, smx_pkg::OP_IMM, smx_pkg::OP_JMP, smx_pkg::OP_CALL,
            smx_pkg::OP_ENT, smx_pkg::OP_ADJ: begin
              if (!loc_word) status_nxt = smx_pkg::STAT_FAULT;
            end
            smx_pkg::OP_JZ, smx_pkg::OP_JNZ: begin
              if ((ax_r == 32'd0) != (rd[5:0] == smx_pkg::OP_JZ)) begin
                pc_nxt = pc_r + 32'd8;
                status_nxt = smx_pkg::STAT_OK;
                out_valid_nxt = 1'b1;
                state_nxt = ST_IDLE;
              end else if (!loc_word) begin
                status_nxt = smx_pkg::STAT_FAULT;
              end
            end
            smx_pkg::OP_LEV: begin
              loc_addr = bp_r;
              if (!loc_word) status_nxt = smx_pkg::STAT_FAULT;
            end
            smx_pkg::OP_LI: begin
              loc_addr = ax_r;
              if (!loc_word) status_nxt = smx_pkg::STAT_FAULT;
            end
            smx_pkg::OP_LC: begin
              loc_addr = ax_r;
              lane_nxt = loc.lane;
              if (!loc.hit) status_nxt = smx_pkg::STAT_FAULT;
            end
            smx_pkg::OP_SI, smx_pkg::OP_SC, smx_pkg::OP_OR, smx_pkg::OP_XOR,
            smx_pkg::OP_AND, smx_pkg::OP_EQ, smx_pkg::OP_NE, smx_pkg::OP_LT,
            smx_pkg::OP_GT, smx_pkg::OP_LE, smx_pkg::OP_GE, smx_pkg::OP_SHL,
            smx_pkg::OP_SHR, smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
            smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
              loc_addr = sp_r;
              if (!loc_word) status_nxt = smx_pkg::STAT_FAULT;
            end
            smx_pkg::OP_PUSH: begin
              loc_addr = sp_r - 32'd4;
              if (!loc_word) begin
                status_nxt = smx_pkg::STAT_FAULT;
              end else begin
                mem_we = 1'b1;
                mem_wdata = ax_r;
                sp_nxt = sp_r - 32'd4;
                pc_nxt = pc_r + 32'd4;
                status_nxt = smx_pkg::STAT_OK;
                out_valid_nxt = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            smx_pkg::OP_LOAD: begin
              ax_nxt = data_base_r |
                       {{(32-smx_pkg::OFF_W){1'b0}}, ax_r[smx_pkg::OFF_W-1:0]};
              pc_nxt = pc_r + 32'd4;
              status_nxt = smx_pkg::STAT_OK;
              out_valid_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
            smx_pkg::OP_EXIT: begin
              pc_nxt = pc_r + 32'd4;
              status_nxt = smx_pkg::STAT_EXIT;
              halted_nxt = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
            default: status_nxt = smx_pkg::STAT_UNKNOWN;
          endcase
        end
        // faults and unknown opcodes end the request here: halt, registers hold
        if (state_nxt == ST_RD1 && (status_nxt == smx_pkg::STAT_FAULT ||
                                    status_nxt == smx_pkg::STAT_UNKNOWN)) begin
          halted_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_RD1: begin
        status_nxt = smx_pkg::STAT_OK;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
        loc_addr = sp_r - 32'd4;
        unique case (op_r)
          smx_pkg::OP_LEA: begin ax_nxt = bp_r + rd; pc_nxt = pc_r + 32'd8; end
          smx_pkg::OP_IMM: begin ax_nxt = rd; pc_nxt = pc_r + 32'd8; end
          smx_pkg::OP_JMP, smx_pkg::OP_JZ, smx_pkg::OP_JNZ:
            pc_nxt = text_base_r + {rd[29:0], 2'b00};
          smx_pkg::OP_ADJ: begin
            sp_nxt = sp_r + {rd[29:0], 2'b00};
            pc_nxt = pc_r + 32'd8;
          end
          smx_pkg::OP_CALL, smx_pkg::OP_ENT: begin
            if (!loc_word) begin
              status_nxt = smx_pkg::STAT_FAULT;
              halted_nxt = 1'b1;
            end else begin
              mem_we = 1'b1;
              if (op_r == smx_pkg::OP_CALL) begin
                mem_wdata = pc_r + 32'd8;
                sp_nxt = sp_r - 32'd4;
                pc_nxt = text_base_r + {rd[29:0], 2'b00};
              end else begin
                mem_wdata = bp_r;
                bp_nxt = sp_r - 32'd4;
                sp_nxt = sp_r - 32'd4 - rd;
                pc_nxt = pc_r + 32'd8;
              end
            end
          end
          smx_pkg::OP_LEV: begin
            loc_addr = bp_r + 32'd4;
            t_nxt = rd;
            if (!loc_word) begin
              status_nxt = smx_pkg::STAT_FAULT;
              halted_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt = ST_RD2;
            end
          end
          smx_pkg::OP_LI: begin ax_nxt = rd; pc_nxt = pc_r + 32'd4; end
          smx_pkg::OP_LC: begin
            ax_nxt = {24'd0, rd[{lane_r, 3'b000} +: 8]};
            pc_nxt = pc_r + 32'd4;
          end
          smx_pkg::OP_SI: begin
            loc_addr = rd;
            if (!loc_word) begin
              status_nxt = smx_pkg::STAT_FAULT;
              halted_nxt = 1'b1;
            end else begin
              mem_we = 1'b1;
              mem_wdata = ax_r;
              sp_nxt = sp_r + 32'd4;
              pc_nxt = pc_r + 32'd4;
            end
          end
          smx_pkg::OP_SC: begin
            loc_addr = rd;
            idx_nxt = loc.idx;
            lane_nxt = loc.lane;
            if (!loc.hit) begin
              status_nxt = smx_pkg::STAT_FAULT;
              halted_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt = ST_RD2;
            end
          end
          smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
            if (ax_r == 32'd0) begin
              status_nxt = smx_pkg::STAT_DIV0;
              halted_nxt = 1'b1;
            end else begin
              quo_nxt = rd[31] ? (32'd0 - rd) : rd;
              dvs_nxt = ax_r[31] ? (32'd0 - ax_r) : ax_r;
              rem_nxt = '0;
              nq_nxt = rd[31] ^ ax_r[31];
              nr_nxt = rd[31];
              cnt_nxt = '0;
              out_valid_nxt = 1'b0;
              state_nxt = ST_DIV;
            end
          end
          default: begin
            ax_nxt = alu_w;
            sp_nxt = sp_r + 32'd4;
            pc_nxt = pc_r + 32'd4;
          end
        endcase
      end

      ST_RD2: begin
        status_nxt = smx_pkg::STAT_OK;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
        mem_waddr = idx_r;
        if (op_r == smx_pkg::OP_LEV) begin
          sp_nxt = bp_r + 32'd8;
          bp_nxt = t_r;
          pc_nxt = rd;
        end else begin
          mem_we = 1'b1;
          mem_wdata = merged;
          sp_nxt = sp_r + 32'd4;
          pc_nxt = pc_r + 32'd4;
        end
      end

      ST_DIV: begin
        if (!diff[32]) begin
          rem_nxt = diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_DFIN;
      end

      ST_DFIN: begin
        ax_nxt = div_w;
        sp_nxt = sp_r + 32'd4;
        pc_nxt = pc_r + 32'd4;
        status_nxt = smx_pkg::STAT_OK;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pc_r          <= '0;
      ax_r          <= '0;
      sp_r          <= 32'd2097152 + smx_pkg::WIN_BYTES;
      bp_r          <= '0;
      halted_r      <= 1'b1;
      status_r      <= smx_pkg::STAT_OK;
      out_valid_r   <= 1'b0;
      text_base_r   <= '0;
      data_base_r   <= 32'd1048576;
      stack_base_r  <= 32'd2097152;
      heap_base_r   <= 32'd3145728;
      entry_index_r <= '0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ax_r        <= ax_nxt;
      sp_r        <= sp_nxt;
      bp_r        <= bp_nxt;
      halted_r    <= halted_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          smx_pkg::CFG_TEXT:  text_base_r   <= cfg_data;
          smx_pkg::CFG_DATA:  data_base_r   <= cfg_data;
          smx_pkg::CFG_STACK: stack_base_r  <= cfg_data;
          smx_pkg::CFG_HEAP:  heap_base_r   <= cfg_data;
          smx_pkg::CFG_ENTRY: entry_index_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    op_r   <= op_nxt;
    t_r    <= t_nxt;
    idx_r  <= idx_nxt;
    lane_r <= lane_nxt;
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    nq_r   <= nq_nxt;
    nr_r   <= nr_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_program_counter = pc_r;
  assign out_accumulator     = ax_r;
  assign out_stack_pointer   = sp_r;
  assign out_frame_pointer   = bp_r;
  assign out_status          = status_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe while busy");

  a_halt_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == smx_pkg::STAT_EXIT || status_r == smx_pkg::STAT_DIV0 ||
                     status_r == smx_pkg::STAT_UNKNOWN)) |-> halted_r)
    else $error("machine not halted after stop status");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dvs_r != 32'd0)
    else $error("divider running on zero divisor");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  // Operation code that the block must ignore
  localparam logic [1:0] OPN_IGNORED = 2'd3;

  // What a missing memory word was wanted for; this decides what gets written there
  localparam int ROLE_OPCODE  = 0;
  localparam int ROLE_OPERAND = 1;
  localparam int ROLE_DATA    = 2;

  typedef struct packed {
    logic [1:0]  opn;
    logic [31:0] addr;
    logic [31:0] data;
  } request_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] ax;
    logic [31:0] sp;
    logic [31:0] bp;
    logic [2:0]  status;
  } regs_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] ax;
    logic [31:0] sp;
    logic [31:0] bp;
  } mach_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic [31:0] out_program_counter;
  logic [31:0] out_accumulator;
  logic [31:0] out_stack_pointer;
  logic [31:0] out_frame_pointer;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  stack_machine_executor i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_program_counter (out_program_counter),
    .out_accumulator     (out_accumulator),
    .out_stack_pointer   (out_stack_pointer),
    .out_frame_pointer   (out_frame_pointer),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  request_t request_q[$];
  regs_t    regs_expected_q[$];
  int       mismatches = 0;

  // ---------------------------------------------------------------------------
  // Machine copy: memory with a written flag per word, window bases and regs.
  // ---------------------------------------------------------------------------
  logic [31:0] vm_mem [MEM_DEPTH];
  bit          vm_seen [MEM_DEPTH];
  logic [31:0] vm_base [SEGMENTS];
  logic [15:0] vm_entry;
  logic [31:0] vm_pc, vm_ax, vm_sp, vm_bp;
  bit          vm_halted;

  // Set when a step would touch a word never written; the step is then not taken
  bit          miss;
  logic [31:0] miss_addr;
  int          miss_role;
  int          fill_role;
  logic [5:0]  cur_op;

  // Walk the windows in order text, data, stack, heap; the first hit wins
  function automatic bit find_word(input logic [31:0] a, output int idx,
                                   output logic [1:0] lane);
    logic [31:0] off;
    idx  = 0;
    lane = '0;
    for (int s = 0; s < SEGMENTS; s++) begin
      off = a - vm_base[s];
      if (off < WIN_BYTES) begin
        idx  = s * SEGMENT_WORDS + int'(off >> 2);
        lane = off[1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit fetch_word(input logic [31:0] a, output logic [31:0] v);
    int         idx;
    logic [1:0] lane;
    v = '0;
    if (!find_word(a, idx, lane) || lane != 2'd0) return 1'b0;
    if (!vm_seen[idx]) begin
      miss      = 1'b1;
      miss_addr = a;
      miss_role = fill_role;
      return 1'b0;
    end
    v = vm_mem[idx];
    return 1'b1;
  endfunction

  function automatic bit fetch_byte(input logic [31:0] a, output logic [31:0] v);
    int         idx;
    logic [1:0] lane;
    v = '0;
    if (!find_word(a, idx, lane)) return 1'b0;
    if (!vm_seen[idx]) begin
      miss      = 1'b1;
      miss_addr = a - 32'(lane);
      miss_role = fill_role;
      return 1'b0;
    end
    v = 32'(vm_mem[idx] >> (8 * lane)) & 32'hff;
    return 1'b1;
  endfunction

  function automatic bit store_word(input logic [31:0] a, input logic [31:0] v);
    int         idx;
    logic [1:0] lane;
    if (!find_word(a, idx, lane) || lane != 2'd0) return 1'b0;
    vm_mem[idx]  = v;
    vm_seen[idx] = 1'b1;
    return 1'b1;
  endfunction

  // A byte store merges into the old word, so an unwritten word counts as a read
  function automatic bit store_byte(input logic [31:0] a, input logic [7:0] v);
    int         idx;
    logic [1:0] lane;
    if (!find_word(a, idx, lane)) return 1'b0;
    if (!vm_seen[idx]) begin
      miss      = 1'b1;
      miss_addr = a - 32'(lane);
      miss_role = fill_role;
      return 1'b0;
    end
    vm_mem[idx][8*lane +: 8] = v;
    return 1'b1;
  endfunction

  // One instruction on a register copy; memory is only touched once all reads passed
  function automatic logic [2:0] exec_instr(inout mach_t r);
    logic [31:0] op, w, a, b, ua, ub;
    fill_role = ROLE_OPCODE;
    if (!fetch_word(r.pc, op)) return STAT_FAULT;
    r.pc += 32'd4;
    if (op > 32'd63) return STAT_UNKNOWN;
    cur_op    = op[5:0];
    fill_role = ROLE_OPERAND;
    case (op[5:0])
      OP_LEA: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        r.ax = r.bp + w;
        r.pc += 32'd4;
        return STAT_OK;
      end
      OP_IMM: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        r.ax = w;
        r.pc += 32'd4;
        return STAT_OK;
      end
      OP_JMP: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        r.pc = vm_base[0] + (w << 2);
        return STAT_OK;
      end
      OP_CALL: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        if (!store_word(r.sp - 32'd4, r.pc + 32'd4)) return STAT_FAULT;
        r.sp -= 32'd4;
        r.pc = vm_base[0] + (w << 2);
        return STAT_OK;
      end
      OP_JZ, OP_JNZ: begin
        // take the branch when ax being zero matches the opcode's sense
        if ((r.ax == 32'd0) == (op[5:0] == OP_JZ)) begin
          if (!fetch_word(r.pc, w)) return STAT_FAULT;
          r.pc = vm_base[0] + (w << 2);
        end else begin
          r.pc += 32'd4;
        end
        return STAT_OK;
      end
      OP_ENT: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        if (!store_word(r.sp - 32'd4, r.bp)) return STAT_FAULT;
        r.sp -= 32'd4;
        r.bp = r.sp;
        r.sp -= w;
        r.pc += 32'd4;
        return STAT_OK;
      end
      OP_ADJ: begin
        if (!fetch_word(r.pc, w)) return STAT_FAULT;
        r.sp += w << 2;
        r.pc += 32'd4;
        return STAT_OK;
      end
      OP_LEV: begin
        fill_role = ROLE_DATA;
        if (!fetch_word(r.bp, a) || !fetch_word(r.bp + 32'd4, b)) return STAT_FAULT;
        r.sp = r.bp + 32'd8;
        r.bp = a;
        r.pc = b;
        return STAT_OK;
      end
      OP_LI: begin
        fill_role = ROLE_DATA;
        if (!fetch_word(r.ax, w)) return STAT_FAULT;
        r.ax = w;
        return STAT_OK;
      end
      OP_LC: begin
        fill_role = ROLE_DATA;
        if (!fetch_byte(r.ax, w)) return STAT_FAULT;
        r.ax = w;
        return STAT_OK;
      end
      OP_SI, OP_SC: begin
        fill_role = ROLE_DATA;
        if (!fetch_word(r.sp, a)) return STAT_FAULT;
        if (op[5:0] == OP_SI ? !store_word(a, r.ax) : !store_byte(a, r.ax[7:0]))
          return STAT_FAULT;
        r.sp += 32'd4;
        return STAT_OK;
      end
      OP_PUSH: begin
        if (!store_word(r.sp - 32'd4, r.ax)) return STAT_FAULT;
        r.sp -= 32'd4;
        return STAT_OK;
      end
      OP_LOAD: begin
        r.ax = vm_base[1] | (r.ax % WIN_BYTES);
        return STAT_OK;
      end
      OP_EXIT: return STAT_EXIT;
      OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL,
      OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        // pop the left operand; ax is the right one
        fill_role = ROLE_DATA;
        if (!fetch_word(r.sp, a)) return STAT_FAULT;
        b = r.ax;
        if ((op[5:0] == OP_DIV || op[5:0] == OP_MOD) && b == 32'd0) return STAT_DIV0;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        case (op[5:0])
          OP_OR:  w = a | b;
          OP_XOR: w = a ^ b;
          OP_AND: w = a & b;
          OP_EQ:  w = 32'(a == b);
          OP_NE:  w = 32'(a != b);
          OP_LT:  w = 32'($signed(a) < $signed(b));
          OP_GT:  w = 32'($signed(a) > $signed(b));
          OP_LE:  w = 32'($signed(a) <= $signed(b));
          OP_GE:  w = 32'($signed(a) >= $signed(b));
          OP_SHL: w = a << b[4:0];
          OP_SHR: w = 32'($signed(a) >>> b[4:0]);
          OP_ADD: w = a + b;
          OP_SUB: w = a - b;
          OP_MUL: w = a * b;
          // magnitudes keep the most negative / -1 case at the most negative value
          OP_DIV: begin
            w = ua / ub;
            if (a[31] != b[31]) w = -w;
          end
          default: begin
            w = ua % ub;
            if (a[31]) w = -w;
          end
        endcase
        r.ax = w;
        r.sp += 32'd4;
        return STAT_OK;
      end
      default: return STAT_UNKNOWN;
    endcase
  endfunction

  // Advance the machine copy by one request; false means a word must be written first
  function automatic bit predict_machine(input logic [1:0] opn, input logic [31:0] a,
                                         input logic [31:0] d, output regs_t res);
    mach_t       r;
    logic [31:0] top;
    logic [31:0] frame [5];
    logic [2:0]  st;
    bit          ok;
    int          idx;
    logic [1:0]  lane;
    st  = STAT_OK;
    res = '0;
    case (opn)
      OPN_WRITE: if (!store_word(a, d)) st = STAT_FAULT;
      OPN_START: begin
        top   = vm_base[2] + WIN_BYTES;
        frame = '{32'd42, 32'd15, 32'd0, 32'd0, top - 32'd8};
        ok    = 1'b1;
        for (int i = 0; i < 5; i++)
          if (!find_word(top - 32'(4 * (i + 1)), idx, lane) || lane != 2'd0) ok = 1'b0;
        if (ok) begin
          for (int i = 0; i < 5; i++) void'(store_word(top - 32'(4 * (i + 1)), frame[i]));
          vm_sp     = top - 32'd20;
          vm_pc     = vm_base[0] + (32'(vm_entry) << 2);
          vm_ax     = '0;
          vm_bp     = '0;
          vm_halted = 1'b0;
        end else begin
          st = STAT_FAULT;
        end
      end
      OPN_STEP: begin
        if (vm_halted) begin
          st = STAT_EXIT;
        end else begin
          miss = 1'b0;
          r    = '{vm_pc, vm_ax, vm_sp, vm_bp};
          st   = exec_instr(r);
          if (miss) return 1'b0;
          if (st <= STAT_EXIT) {vm_pc, vm_ax, vm_sp, vm_bp} = r;
          if (st != STAT_OK) vm_halted = 1'b1;
        end
      end
      default: ;
    endcase
    res = '{vm_pc, vm_ax, vm_sp, vm_bp, st};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4, 5: return 32'($urandom_range(0, 40));
      6, 7: return vm_base[$urandom_range(0, 3)] + 32'($urandom_range(0, 1023) << 2)
                   + ($urandom_range(0, 15) == 0 ? 32'($urandom_range(1, 3)) : 32'd0);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_opcode();
    logic [5:0] legal [30] = '{OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT,
                              OP_ADJ, OP_LEV, OP_LI, OP_SI, OP_LC, OP_SC, OP_PUSH,
                              OP_LOAD, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT,
                              OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB,
                              OP_MUL, OP_DIV};
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) return $urandom;
    if (k < 5) begin
      case ($urandom_range(0, 3))
        0: return 32'd0;
        1: return 32'd3;
        2: return 32'($urandom_range(33, 41));
        default: return 32'($urandom_range(43, 63));
      endcase
    end
    if (k < 9) return 32'(OP_EXIT);
    if (k < 13) return 32'(OP_MOD);
    return 32'(legal[$urandom_range(0, 29)]);
  endfunction

  // Content for a word first needed by the program, shaped by what needs it
  function automatic logic [31:0] fill_value(input int role);
    if (role == ROLE_OPCODE) return pick_opcode();
    if (role == ROLE_DATA) return pick_value();
    case (cur_op)
      OP_JMP, OP_CALL, OP_JZ, OP_JNZ:
        return $urandom_range(0, 15) == 0 ? $urandom : 32'($urandom_range(0, 48));
      OP_ENT: return $urandom_range(0, 15) == 0 ? $urandom : 32'($urandom_range(0, 8) * 4);
      OP_ADJ: return $urandom_range(0, 15) == 0 ? $urandom : 32'($urandom_range(0, 4));
      default: return pick_value();
    endcase
  endfunction

  // Queue one request with its expected registers, first writing any word it would
  // read before anything has been stored there
  task automatic issue(input logic [1:0] opn, input logic [31:0] a, input logic [31:0] d);
    regs_t res;
    while (!predict_machine(opn, a, d, res))
      issue(OPN_WRITE, miss_addr, fill_value(miss_role));
    request_q.push_back('{opn, a, d});
    regs_expected_q.push_back(res);
  endtask

  task automatic write_program(input logic [31:0] words [$]);
    foreach (words[i]) issue(OPN_WRITE, vm_base[0] + 32'(4 * i), words[i]);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEXT:  vm_base[0] = v;
      CFG_DATA:  vm_base[1] = v;
      CFG_STACK: vm_base[2] = v;
      CFG_HEAP:  vm_base[3] = v;
      default:   vm_entry = v[15:0];
    endcase
  endtask

  task automatic set_windows(input logic [31:0] t, input logic [31:0] dt,
                             input logic [31:0] st, input logic [31:0] hp,
                             input logic [31:0] en);
    set_reg(CFG_TEXT, t);
    set_reg(CFG_DATA, dt);
    set_reg(CFG_STACK, st);
    set_reg(CFG_HEAP, hp);
    set_reg(CFG_ENTRY, en);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every request has its result, then let the divider settle
  task automatic drain();
    while (request_q.size() != 0 || regs_expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Mostly run the program; restart after a halt, with writes and noise mixed in
  task automatic run_phase(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (vm_halted) begin
        if (k < 85)      issue(OPN_START, $urandom, $urandom);
        else if (k < 95) issue(OPN_STEP, $urandom, $urandom);
        else             issue(OPN_IGNORED, $urandom, $urandom);
      end else if (k < 88) begin
        issue(OPN_STEP, $urandom, $urandom);
      end else if (k < 94) begin
        issue(OPN_WRITE, k[0] ? pick_value() : $urandom, $urandom);
      end else if (k < 97) begin
        issue(OPN_START, $urandom, $urandom);
      end else begin
        issue(OPN_IGNORED, $urandom, $urandom);
      end
    end
  endtask

  function automatic void reset_machine();
    foreach (vm_seen[i]) vm_seen[i] = 1'b0;
    vm_base   = '{32'd0, 32'd1048576, 32'd2097152, 32'd3145728};
    vm_entry  = '0;
    vm_ax     = '0;
    vm_bp     = '0;
    vm_sp     = vm_base[2] + WIN_BYTES;
    vm_pc     = vm_base[0];
    vm_halted = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #6ms;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; hold each until it is taken
  // ---------------------------------------------------------------------------
  logic took = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(posedge clk) took <= start && !busy;

  always @(negedge clk) begin
    request_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold: the request has not been taken yet
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (request_q.size() != 0) begin
      req = request_q.pop_front();
      start         <= 1'b1;
      in_operation  <= req.opn;
      in_address    <= req.addr;
      in_write_data <= req.data;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // long back-to-back stretches now and then, otherwise short gaps
        burst_left = $urandom_range(1, 24);
        gap_left   = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 10);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobed result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    regs_t want;
    if (rst_n && out_valid) begin
      if (regs_expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, status", 32'(out_status), 32'd0);
      end else begin
        want = regs_expected_q.pop_front();
        if (out_program_counter !== want.pc)
          report_mismatch("program_counter", out_program_counter, want.pc);
        if (out_accumulator !== want.ax)
          report_mismatch("accumulator", out_accumulator, want.ax);
        if (out_stack_pointer !== want.sp)
          report_mismatch("stack_pointer", out_stack_pointer, want.sp);
        if (out_frame_pointer !== want.bp)
          report_mismatch("frame_pointer", out_frame_pointer, want.bp);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corner cases, then random phases over several window maps
  // ---------------------------------------------------------------------------
  initial begin
    reset_machine();
    wait (rst_n);

    // step before any start, ignored code, unmapped, misaligned and last-text-word writes
    issue(OPN_STEP, 32'd0, 32'd0);
    issue(OPN_IGNORED, 32'hffff_ffff, 32'hffff_ffff);
    issue(OPN_WRITE, 32'h7fff_fff0, 32'h1234_5678);
    issue(OPN_WRITE, 32'd2, 32'hdead_beef);
    issue(OPN_WRITE, 32'h0000_0ffc, 32'hffff_ffff);
    // most negative / -1, then remainder by zero
    write_program('{32'(OP_IMM), 32'h8000_0000, 32'(OP_PUSH), 32'(OP_IMM), 32'hffff_ffff,
                    32'(OP_DIV), 32'(OP_PUSH), 32'(OP_IMM), 32'd0, 32'(OP_MOD)});
    issue(OPN_START, 32'd0, 32'd0);
    repeat (8) issue(OPN_STEP, 32'd0, 32'd0);
    run_phase(140);

    // text window at the top of the space, heap straddling the wrap
    drain();
    set_windows(32'hffff_f000, 32'h0000_0000, 32'h0020_0000, 32'hffff_ffff, 32'd5);
    run_phase(140);

    // data shadowed by text, entry at its largest
    drain();
    set_windows(32'h0000_1000, 32'h0000_1000, 32'h0000_3000, 32'h0000_2000, 32'hffff);
    run_phase(60);

    // stack top wraps to zero
    drain();
    set_windows(32'h0004_0000, 32'h0008_0000, 32'hffff_f000, 32'h0000_0000, 32'd0);
    run_phase(140);

    // random map, now and then with a misaligned stack base
    drain();
    set_windows($urandom & 32'hffff_fffc, $urandom & 32'hffff_f000,
                $urandom_range(0, 7) == 0 ? $urandom : ($urandom & 32'hffff_fffc),
                $urandom, 32'($urandom_range(0, 15)));
    run_phase(200);

    drain();
    if (regs_expected_q.size() != 0)
      report_mismatch("results never seen", 32'(regs_expected_q.size()), 32'd0);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
